FILE: rtl/mbrx_pkg.sv
// Shared types, constants and helpers for the Modbus ASCII receive deframer.
`default_nettype none

package mbrx_pkg;

  localparam int unsigned MaxFrameBytesDefault = 256;

  // Framing characters
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Receive phase codes
  localparam logic [1:0] PhaseIdle   = 2'd0;
  localparam logic [1:0] PhaseCollect = 2'd1;
  localparam logic [1:0] PhaseWaitLf = 2'd2;

  // Result kinds
  localparam logic KindData  = 1'b0;
  localparam logic KindFrame = 1'b1;

  // Frame control state, count held apart as its width follows the parameter
  typedef struct packed {
    logic [1:0] phase;
    logic       nibble_phase;
    logic [3:0] high_nibble;
    logic       overflow_seen;
  } ctl_t;

  // One result word
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [8:0] frame_length;
    logic       overflow;
  } res_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/modbus_ascii_rx_deframer_core.sv
// Top level of the Modbus ASCII receive deframer.
`default_nettype none

// Takes one received character per input word and turns Modbus ASCII framing
// into data-byte words and frame-complete words. A colon starts (or restarts)
// a frame from any state; hex digits are paired high nibble first into bytes,
// each emitted with its index; CR then LF closes the frame with its byte count
// and an overflow flag. Bytes beyond MaxFrameBytes are dropped and flagged; a
// lone trailing nibble is discarded. Throughput is one character per clock
// while the output does not stall: an input register feeds combinational
// decode logic, which loads a result register on the way to the output.
// Input stall rises only when both registers hold words and the output side
// stalls. Characters that yield no result only update state.
module modbus_ascii_rx_deframer_core #(
  parameter int unsigned MaxFrameBytes = mbrx_pkg::MaxFrameBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [8:0]      frame_length_o,
  output logic            overflow_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);

  // Input register
  logic       in_valid_q;
  logic [7:0] char_q;

  // Frame state
  mbrx_pkg::ctl_t  ctl_q, ctl_d;
  logic [CntW-1:0] count_q, count_d;

  // Result register
  logic           out_valid_q;
  mbrx_pkg::res_t res_q, res_d;
  logic           res_valid;

  logic advance;   // input register word is consumed this cycle
  logic take_in;

  // The held character may move on whenever the result register is free or
  // being emptied; this is independent of whether it yields a result.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  mbrx_step #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_step (
    .rx_char_i  (char_q),
    .ctl_i      (ctl_q),
    .count_i    (count_q),
    .ctl_o      (ctl_d),
    .count_o    (count_d),
    .res_valid_o(res_valid),
    .res_o      (res_d)
  );

  // Control: input valid, frame state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctl_q       <= '0;
      count_q     <= '0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        ctl_q   <= ctl_d;
        count_q <= count_d;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      char_q <= rx_char_i;
    end
    if (advance && res_valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign data_byte_o    = res_q.data_byte;
  assign byte_index_o   = res_q.byte_index;
  assign frame_length_o = res_q.frame_length;
  assign overflow_o     = res_q.overflow;

  // The count never passes the frame limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxFrameBytes))
    else $error("byte count above frame limit");

  // Overflow can only be flagged once the frame is full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.overflow_seen |-> (count_q == CntW'(MaxFrameBytes)))
    else $error("overflow flagged on a frame that is not full");

  // A data byte word bumps the count by one
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && (res_d.kind == mbrx_pkg::KindData))
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("data byte emitted without count increment");

  // A frame-complete word returns the receiver to idle
  a_frame_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && (res_d.kind == mbrx_pkg::KindFrame))
      |=> (ctl_q.phase == mbrx_pkg::PhaseIdle))
    else $error("frame complete without return to idle");

  // Input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && in_valid_q))
    else $error("input stalled without back-pressure");

endmodule

`default_nettype wire

FILE: rtl/mbrx_step.sv
// Per-character next-state and result logic of the deframer.
`default_nettype none

module mbrx_step #(
  parameter int unsigned MaxFrameBytes = mbrx_pkg::MaxFrameBytesDefault,
  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1)
) (
  input  wire logic [7:0]      rx_char_i,
  input  wire mbrx_pkg::ctl_t  ctl_i,
  input  wire logic [CntW-1:0] count_i,
  output mbrx_pkg::ctl_t       ctl_o,
  output logic [CntW-1:0]      count_o,
  output logic                 res_valid_o,
  output mbrx_pkg::res_t       res_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxFrameBytes);

  logic [4:0] hex;
  logic [8:0] cnt_lo;   // low bits of the count, as carried in result words

  assign hex    = mbrx_pkg::hex_decode(rx_char_i);
  assign cnt_lo = 9'(count_i);

  always_comb begin
    ctl_o       = ctl_i;
    count_o     = count_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (rx_char_i == mbrx_pkg::ChColon) begin
      ctl_o.phase         = mbrx_pkg::PhaseCollect;
      ctl_o.nibble_phase  = 1'b0;
      ctl_o.high_nibble   = 4'd0;
      ctl_o.overflow_seen = 1'b0;
      count_o             = '0;
    end else begin
      case (ctl_i.phase)
        mbrx_pkg::PhaseCollect: begin
          if (rx_char_i == mbrx_pkg::ChCr) begin
            ctl_o.phase        = mbrx_pkg::PhaseWaitLf;
            ctl_o.nibble_phase = 1'b0;
          end else if (hex[4]) begin
            if (!ctl_i.nibble_phase) begin
              ctl_o.high_nibble  = hex[3:0];
              ctl_o.nibble_phase = 1'b1;
            end else begin
              ctl_o.nibble_phase = 1'b0;
              if (count_i >= MaxCnt) begin
                ctl_o.overflow_seen = 1'b1;
              end else begin
                res_valid_o      = 1'b1;
                res_o.kind       = mbrx_pkg::KindData;
                res_o.data_byte  = {ctl_i.high_nibble, hex[3:0]};
                res_o.byte_index = cnt_lo[7:0];
                count_o          = count_i + 1'b1;
              end
            end
          end
        end
        mbrx_pkg::PhaseWaitLf: begin
          if (rx_char_i == mbrx_pkg::ChLf) begin
            ctl_o.phase        = mbrx_pkg::PhaseIdle;
            res_valid_o        = 1'b1;
            res_o.kind         = mbrx_pkg::KindFrame;
            res_o.frame_length = cnt_lo;
            res_o.overflow     = ctl_i.overflow_seen;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/modbus_ascii_rx_deframer_core_tb.sv
// Testbench for the Modbus ASCII receive deframer: randomised frames, self-checking predictor.
`default_nettype none

module modbus_ascii_rx_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameCap   = mbrx_pkg::MaxFrameBytesDefault;
  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned StallLimit = 3000;  // cycles with no word moving on either side
  localparam int unsigned HoldOff    = 400;   // long receiver hold-off, in cycles
  localparam int unsigned HoldAtWord = 150;   // output word count that triggers it

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_char = 8'h00;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic       kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] byte_index_o;
  logic [8:0] frame_length_o;
  logic       overflow_o;

  modbus_ascii_rx_deframer_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_char_i      (rx_char),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .overflow_o     (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the framing state, fed with every accepted character.
  // ---------------------------------------------------------------------------
  logic [1:0]  frm_phase   = mbrx_pkg::PhaseIdle;
  logic        nib_pending = 1'b0;
  logic [3:0]  nib_hi      = 4'd0;
  int unsigned kept_bytes  = 0;
  logic        bytes_lost  = 1'b0;

  mbrx_pkg::res_t expected_words[$];

  int unsigned n_chars       = 0;
  int unsigned n_data        = 0;
  int unsigned n_frames      = 0;
  int unsigned n_over_frames = 0;
  int unsigned longest_frame = 0;
  int unsigned errors        = 0;

  // Hex digit check: low four bits of '0'..'9' are the value, letters are offset by 9
  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] val);
    val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      val = c[3:0];
      return 1'b1;
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      val = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void deframe_char(input logic [7:0] c);
    logic [3:0]     v;
    mbrx_pkg::res_t w;
    n_chars++;
    // colon restarts the frame whatever the phase
    if (c == mbrx_pkg::ChColon) begin
      frm_phase   = mbrx_pkg::PhaseCollect;
      nib_pending = 1'b0;
      nib_hi      = 4'd0;
      kept_bytes  = 0;
      bytes_lost  = 1'b0;
      return;
    end
    if (frm_phase == mbrx_pkg::PhaseCollect) begin
      if (c == mbrx_pkg::ChCr) begin
        // a lone high nibble is thrown away here
        frm_phase   = mbrx_pkg::PhaseWaitLf;
        nib_pending = 1'b0;
      end else if (hex_digit(c, v)) begin
        if (!nib_pending) begin
          nib_hi      = v;
          nib_pending = 1'b1;
        end else begin
          nib_pending = 1'b0;
          if (kept_bytes >= FrameCap) begin
            bytes_lost = 1'b1;
          end else begin
            w            = '0;
            w.kind       = mbrx_pkg::KindData;
            w.data_byte  = {nib_hi, v};
            w.byte_index = kept_bytes[7:0];
            expected_words.push_back(w);
            kept_bytes++;
            n_data++;
          end
        end
      end
    end else if (frm_phase == mbrx_pkg::PhaseWaitLf && c == mbrx_pkg::ChLf) begin
      frm_phase      = mbrx_pkg::PhaseIdle;
      w              = '0;
      w.kind         = mbrx_pkg::KindFrame;
      w.frame_length = kept_bytes[8:0];
      w.overflow     = bytes_lost;
      expected_words.push_back(w);
      n_frames++;
      if (bytes_lost) n_over_frames++;
      if (kept_bytes > longest_frame) longest_frame = kept_bytes;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [7:0] char_queue[$];

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  // any character that neither starts nor ends anything
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == mbrx_pkg::ChColon || c == mbrx_pkg::ChCr || c == mbrx_pkg::ChLf);
    return c;
  endfunction

  // One frame of nbytes bytes; unless clean it may carry noise, an odd nibble,
  // or be cut short before CR or LF.
  task automatic queue_frame(input int unsigned nbytes, input bit clean);
    int unsigned ending;
    char_queue.push_back(mbrx_pkg::ChColon);
    for (int unsigned i = 0; i < 2 * nbytes; i++) begin
      if (!clean && $urandom_range(0, 15) == 0) char_queue.push_back(noise_char());
      char_queue.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    if (!clean && $urandom_range(0, 5) == 0)
      char_queue.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    ending = clean ? 2 : $urandom_range(0, 19);
    if (ending == 0) return;              // cut before CR; next colon restarts
    char_queue.push_back(mbrx_pkg::ChCr);
    if (ending == 1) return;              // CR but no LF
    if (!clean && $urandom_range(0, 4) == 0) char_queue.push_back(noise_char());
    char_queue.push_back(mbrx_pkg::ChLf);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) char_queue.push_back(noise_char());
    end
  endtask

  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver: drives at the falling edge, sees acceptance from the rising edge
  // ---------------------------------------------------------------------------
  bit          in_fire  = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned in_mode  = 0;
  int unsigned in_count = 0;

  always @(posedge clk_i) begin : take_chars
    if (rst_ni && in_valid && !in_stall_o) begin
      deframe_char(rx_char);
      in_fire = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_chars
    logic next_valid;
    next_valid = in_valid;
    if (rst_ni) begin
      if (in_fire) begin
        in_fire    = 1'b0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (char_queue.size() > 0) begin
          if (in_count % 48 == 0) in_mode = $urandom_range(0, 2);
          rx_char    <= char_queue.pop_front();
          next_valid = 1'b1;
          in_gap     = draw_wait(in_mode);
          in_count++;
        end
      end
    end
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks at the rising edge, stalls from the falling edge
  // ---------------------------------------------------------------------------
  bit          out_fire  = 1'b0;
  int unsigned out_wait  = 0;
  int unsigned out_mode  = 0;
  int unsigned out_words = 0;
  int unsigned hold_left = 0;
  bit          held      = 1'b0;

  always @(posedge clk_i) begin : check_words
    mbrx_pkg::res_t w;
    if (rst_ni && out_valid_o && !out_stall) begin
      out_fire = 1'b1;
      out_words++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d byte %0h index %0d length %0d overflow %0d",
               kind_o, data_byte_o, byte_index_o, frame_length_o, overflow_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (kind_o !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, kind_o);
          errors++;
        end
        if (data_byte_o !== w.data_byte) begin
          $error("data_byte: expected %0h, got %0h", w.data_byte, data_byte_o);
          errors++;
        end
        if (byte_index_o !== w.byte_index) begin
          $error("byte_index: expected %0d, got %0d", w.byte_index, byte_index_o);
          errors++;
        end
        if (frame_length_o !== w.frame_length) begin
          $error("frame_length: expected %0d, got %0d", w.frame_length, frame_length_o);
          errors++;
        end
        if (overflow_o !== w.overflow) begin
          $error("overflow: expected %0d, got %0d", w.overflow, overflow_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : drive_stall
    logic next_stall;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (out_fire) begin
        out_fire = 1'b0;
        if (out_words % 40 == 0) out_mode = $urandom_range(0, 2);
        out_wait = draw_wait(out_mode);
        // one long hold-off so the block backs up and stalls its input
        if (!held && out_words >= HoldAtWord) begin
          held      = 1'b1;
          hold_left = HoldOff;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        next_stall = 1'b1;
      end
    end
    out_stall <= next_stall;
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles in which no word moves on either side
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles = 0;
    end else if (char_queue.size() > 0 || in_valid || expected_words.size() > 0) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d words still expected", expected_words.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [7:0] directed[$];
    bit         exact_done;
    bit         over_done;
    exact_done = 1'b0;
    over_done  = 1'b0;
    rst_ni     = 1'b0;

    // idle junk, byte extremes, non-hex between nibbles, odd nibble at CR,
    // junk and a colon while waiting for LF, then an empty frame
    directed = '{8'h41, 8'h00, 8'hFF,
                 mbrx_pkg::ChColon, 8'h30, 8'h30, 8'h46, 8'h66, 8'h61, 8'h47, 8'h39,
                 8'h37, mbrx_pkg::ChCr,
                 8'h78, mbrx_pkg::ChColon, 8'h41, 8'h65, mbrx_pkg::ChCr, mbrx_pkg::ChLf,
                 mbrx_pkg::ChColon, mbrx_pkg::ChCr, mbrx_pkg::ChLf};
    foreach (directed[i]) char_queue.push_back(directed[i]);

    while (char_queue.size() < ItemTarget) begin
      if (!exact_done && char_queue.size() > 300) begin
        queue_frame(FrameCap, 1'b1);                        // exactly full
        exact_done = 1'b1;
      end else if (!over_done && char_queue.size() > 900) begin
        queue_frame(FrameCap + $urandom_range(1, 4), 1'b1); // bytes dropped
        over_done = 1'b1;
      end else begin
        queue_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8),
                    1'b0);
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (char_queue.size() > 0 || in_valid) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d characters: %0d data bytes, %0d closed frames (longest %0d bytes)",
             n_chars, n_data, n_frames, longest_frame);
    $display("%0d frames overflowed; receiver held off %0d cycles once", n_over_frames, HoldOff);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/mbrx_pkg.sv
rtl/mbrx_step.sv
rtl/modbus_ascii_rx_deframer_core.sv
tb/modbus_ascii_rx_deframer_core_tb.sv
